### rtl/trmp_pkg.sv
// ----------------------------------------------------------------------------
// trmp_pkg
// shared widths, field types, register codes and limits of the truss
// return-mapping block
// ----------------------------------------------------------------------------
package trmp_pkg;

  localparam int DATA_W    = 32;   // strains, stresses, prestress
  localparam int MOD_W     = 31;   // moduli, yield stress, alpha
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_YOUNGS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HARDENING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_YIELD     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESTRESS = 2'd3;

  // serial multiplier walks all bits of a 31-bit modulus
  localparam int MUL_STEPS = MOD_W;

  // plastic multiplier increment is limited to 2^40
  localparam int DG_QB = 41;
  localparam logic [DG_QB-1:0] DG_CAP = {1'b1, {(DG_QB-1){1'b0}}};

  localparam logic [DATA_W-1:0] STRESS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] STRESS_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [MOD_W-1:0]  MOD_MAX    = {MOD_W{1'b1}};

  typedef logic signed [DATA_W-1:0] strain_t;
  typedef logic signed [DATA_W-1:0] stress_t;
  typedef logic        [MOD_W-1:0]  modulus_t;

endpackage

### rtl/trmp_in_if.sv
// ----------------------------------------------------------------------------
// trmp_in_if
// input channel: one total strain and a trial/commit bit per transfer
// ----------------------------------------------------------------------------
interface trmp_in_if import trmp_pkg::*; ();

  logic    valid;
  logic    ready;
  strain_t axial_strain;
  logic    mode;

  modport source (output valid, output axial_strain, output mode, input ready);
  modport sink   (input valid, input axial_strain, input mode, output ready);

endinterface

### rtl/trmp_out_if.sv
// ----------------------------------------------------------------------------
// trmp_out_if
// result channel: stress, tangent and updated internal variables
// ----------------------------------------------------------------------------
interface trmp_out_if import trmp_pkg::*; ();

  logic     valid;
  logic     ready;
  stress_t  stress;
  modulus_t tangent_modulus;
  logic     plastic_step;
  strain_t  plastic_strain_out;
  modulus_t hardening_out;

  modport source (
    output valid, output stress, output tangent_modulus, output plastic_step,
    output plastic_strain_out, output hardening_out, input ready
  );
  modport sink (
    input valid, input stress, input tangent_modulus, input plastic_step,
    input plastic_strain_out, input hardening_out, output ready
  );

endinterface

### rtl/truss_return_mapping_plasticity.sv
// ----------------------------------------------------------------------------
// truss_return_mapping_plasticity
// one-dimensional return mapping with linear isotropic hardening
// ----------------------------------------------------------------------------
// One integration point per transfer. The trial stress E*(strain - eps_p) +
// prestress is checked against yield + H*alpha; a yielding point is returned
// to the yield surface and reports the hardened tangent E*H/(E+H). A commit
// transfer (mode 1) stores the updated plastic strain and alpha, a trial
// transfer only reports them. All products go through one shift-add
// multiplier that retires one bit of a 31-bit modulus per cycle, and all
// quotients through one restoring divider that retires one quotient bit per
// cycle, so an item is handled alone: an elastic point takes three products,
// a plastic one two more products and three divisions by E+H, with the
// strain in Q1.30 by default. The result sits in an output register, so
// the next item is taken while it waits to be collected.
// ----------------------------------------------------------------------------
module truss_return_mapping_plasticity
  import trmp_pkg::*;
#(
  parameter int STRAIN_FRAC_BITS = 30
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  trmp_in_if.sink              in_ch,
  trmp_out_if.source           out_ch
);

  // widths that follow from the strain format
  localparam int FB    = STRAIN_FRAC_BITS;
  localparam int MAG_W = 64 - FB;            // bound on |trial stress|
  localparam int S_W   = MAG_W + 1;          // signed stress / yield function
  localparam int ACC_W = 95 - FB;            // widest product, f*E
  localparam int QN_W  = (MAG_W > DG_QB) ? MAG_W : DG_QB;
  localparam int QC_W  = $clog2(QN_W + 1);
  localparam int MC_W  = $clog2(MUL_STEPS);
  localparam int TAN_QB = MOD_W;
  localparam int PL_W  = DG_QB + 2;
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FB - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_STEP = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // operation in flight
  localparam logic [2:0] PH_EL      = 3'd0;  // |strain - eps_p| * E
  localparam logic [2:0] PH_HARD    = 3'd1;  // H * alpha
  localparam logic [2:0] PH_CHECK   = 3'd2;  // E * strain for the zero test
  localparam logic [2:0] PH_RED_MUL = 3'd3;  // f * E
  localparam logic [2:0] PH_RED_DIV = 3'd4;  // f*E / (E+H)
  localparam logic [2:0] PH_DG_DIV  = 3'd5;  // f*2^F / (E+H)
  localparam logic [2:0] PH_TAN_MUL = 3'd6;  // E * H
  localparam logic [2:0] PH_TAN_DIV = 3'd7;  // E*H / (E+H)

  logic [2:0] state_r, state_nxt;
  logic [2:0] ph_r, ph_nxt;

  // configuration
  logic [MOD_W-1:0]  e_r, h_r, ys_r;
  logic [DATA_W-1:0] pre_r;

  // committed material state
  logic [DATA_W-1:0] pl_r;
  logic [MOD_W-1:0]  al_r;
  logic              flag_r;

  // per-item registers
  logic [DATA_W-1:0] strain_r;
  logic              commit_r;
  logic              diff_neg_r;
  logic [DATA_W-1:0] d_r;            // E + H
  logic [S_W-1:0]    s_r;            // trial stress
  logic [S_W-1:0]    f_r;            // yield function
  logic              plastic_r;
  logic [MAG_W-1:0]  red_r;          // stress reduction
  logic [DG_QB-1:0]  dg_r;           // plastic multiplier in strain units
  logic [MOD_W-1:0]  tan_r;

  // serial multiplier
  logic [ACC_W-1:0]  a_r, acc_r;
  logic [MOD_W-1:0]  b_r;
  logic [MC_W-1:0]   mcnt_r;

  // serial divider
  logic [DATA_W-1:0] rem_r;
  logic [QN_W-1:0]   num_r, quo_r;
  logic [QC_W-1:0]   dcnt_r;
  logic              ovf_r;

  // result register
  logic              out_valid_r;
  logic [DATA_W-1:0] o_stress_r, o_pl_r;
  logic [MOD_W-1:0]  o_tan_r, o_al_r;
  logic              o_plastic_r;

  logic in_fire, fin_fire, out_free, mul_last, div_last, mul_start, div_start;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign fin_fire    = (state_r == S_FIN) && out_free;
  assign mul_last    = (mcnt_r == MC_W'(MUL_STEPS - 1));
  assign div_last    = (dcnt_r == QC_W'(1));

  // ---------------------------------------------------------------- trial math
  logic [DATA_W:0]   diff, dmag;
  logic [ACC_W-1:0]  rnd_sum;
  logic [MAG_W-1:0]  rnd_q;          // product rounded half away from zero
  logic [S_W-1:0]    pre_s, s_calc, s_abs, thr, f_calc;
  logic [ACC_W-1:0]  pre_acc, chk;
  logic              plastic_now;
  logic [MAG_W-1:0]  f_mag;
  logic [ACC_W-1:0]  f_shift;

  assign diff = {in_ch.axial_strain[DATA_W-1], in_ch.axial_strain}
              - {pl_r[DATA_W-1], pl_r};
  assign dmag = diff[DATA_W] ? (~diff + 1'b1) : diff;

  assign rnd_sum = acc_r + RND_HALF;
  assign rnd_q   = rnd_sum[FB +: MAG_W];

  assign pre_s  = {{(S_W-DATA_W){pre_r[DATA_W-1]}}, pre_r};
  assign s_calc = diff_neg_r ? (pre_s - {1'b0, rnd_q}) : (pre_s + {1'b0, rnd_q});
  assign s_abs  = s_r[S_W-1] ? (~s_r + 1'b1) : s_r;
  assign thr    = {{(S_W-MOD_W){1'b0}}, ys_r} + {1'b0, rnd_q};
  assign f_calc = s_abs - thr;

  // elastic is forced when E*strain + prestress*2^F is exactly zero
  assign pre_acc = {{(ACC_W-DATA_W){pre_r[DATA_W-1]}}, pre_r} << FB;
  assign chk     = acc_r + pre_acc;
  assign plastic_now = !f_r[S_W-1] && (f_r != '0) && (chk != '0);

  assign f_mag   = f_r[MAG_W-1:0];
  assign f_shift = {{(ACC_W-MAG_W){1'b0}}, f_mag} << FB;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_MUL;
          ph_nxt    = PH_EL;
        end
      end
      S_MUL: begin
        if (mul_last) state_nxt = S_STEP;
      end
      S_DIV: begin
        if (div_last) state_nxt = S_STEP;
      end
      S_STEP: begin
        unique case (ph_r)
          PH_EL: begin
            state_nxt = S_MUL;
            ph_nxt    = PH_HARD;
          end
          PH_HARD: begin
            state_nxt = S_MUL;
            ph_nxt    = PH_CHECK;
          end
          PH_CHECK: begin
            if (plastic_now) begin
              state_nxt = S_MUL;
              ph_nxt    = PH_RED_MUL;
            end else begin
              state_nxt = S_FIN;
            end
          end
          PH_RED_MUL: begin
            state_nxt = S_DIV;
            ph_nxt    = PH_RED_DIV;
          end
          PH_RED_DIV: begin
            state_nxt = S_DIV;
            ph_nxt    = PH_DG_DIV;
          end
          PH_DG_DIV: begin
            state_nxt = S_MUL;
            ph_nxt    = PH_TAN_MUL;
          end
          PH_TAN_MUL: begin
            state_nxt = S_DIV;
            ph_nxt    = PH_TAN_DIV;
          end
          PH_TAN_DIV: begin
            state_nxt = S_FIN;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign mul_start = in_fire || ((state_r == S_STEP) && (state_nxt == S_MUL));
  assign div_start = (state_r == S_STEP) && (state_nxt == S_DIV);

  // multiplier operands for the next product
  logic [ACC_W-1:0] mul_a_in;
  logic [MOD_W-1:0] mul_b_in;

  always_comb begin
    mul_a_in = {{(ACC_W-DATA_W-1){1'b0}}, dmag};
    mul_b_in = e_r;
    case (ph_nxt)
      PH_HARD: begin
        mul_a_in = {{(ACC_W-MOD_W){1'b0}}, al_r};
        mul_b_in = h_r;
      end
      PH_CHECK: begin
        mul_a_in = {{(ACC_W-DATA_W){strain_r[DATA_W-1]}}, strain_r};
        mul_b_in = e_r;
      end
      PH_RED_MUL: begin
        mul_a_in = {{(ACC_W-MAG_W){1'b0}}, f_mag};
        mul_b_in = e_r;
      end
      PH_TAN_MUL: begin
        mul_a_in = {{(ACC_W-MOD_W){1'b0}}, e_r};
        mul_b_in = h_r;
      end
      default: ;
    endcase
  end

  // divider setup: leading part of the numerator goes to the remainder,
  // the rest is left-aligned in the numerator shift register
  logic [ACC_W-1:0]  red_hi, red_lo, dg_hi, dg_lo, tan_hi, tan_lo;
  logic [DATA_W-1:0] div_rem_in;
  logic [QN_W-1:0]   div_num_in;
  logic [QC_W-1:0]   div_cnt_in;
  logic              div_ovf_in;

  assign red_hi = acc_r >> MAG_W;
  assign red_lo = acc_r << (QN_W - MAG_W);
  assign dg_hi  = f_shift >> DG_QB;
  assign dg_lo  = f_shift << (QN_W - DG_QB);
  assign tan_hi = acc_r >> TAN_QB;
  assign tan_lo = acc_r << (QN_W - TAN_QB);

  always_comb begin
    div_rem_in = red_hi[DATA_W-1:0];
    div_num_in = red_lo[QN_W-1:0];
    div_cnt_in = QC_W'(MAG_W);
    div_ovf_in = 1'b0;
    case (ph_nxt)
      PH_DG_DIV: begin
        // quotient of 2^41 or more is capped anyway
        div_ovf_in = (dg_hi >= {{(ACC_W-DATA_W){1'b0}}, d_r});
        div_rem_in = div_ovf_in ? '0 : dg_hi[DATA_W-1:0];
        div_num_in = dg_lo[QN_W-1:0];
        div_cnt_in = QC_W'(DG_QB);
      end
      PH_TAN_DIV: begin
        div_rem_in = tan_hi[DATA_W-1:0];
        div_num_in = tan_lo[QN_W-1:0];
        div_cnt_in = QC_W'(TAN_QB);
      end
      default: ;
    endcase
  end

  // one restoring step
  logic [DATA_W:0] div_t, div_diff;
  logic            div_ge;

  assign div_t    = {rem_r, num_r[QN_W-1]};
  assign div_ge   = (div_t >= {1'b0, d_r});
  assign div_diff = div_t - {1'b0, d_r};

  // ---------------------------------------------------------------- final update
  logic [S_W-1:0]    s_new;
  logic [S_W:0]      os_full;
  logic [S_W:DATA_W-1] os_hi;
  logic [DATA_W-1:0] stress_sat;
  logic [PL_W-1:0]   pl_ext, pl_sum;
  logic [PL_W-1:DATA_W-1] pl_hi;
  logic [DATA_W-1:0] pl_sat, new_pl;
  logic [DG_QB:0]    al_sum;
  logic [MOD_W-1:0]  new_al, tan_out;
  logic [DG_QB-1:0]  dg_calc;

  assign dg_calc = (ovf_r || quo_r[DG_QB-1]) ? DG_CAP : quo_r[DG_QB-1:0];

  // return toward zero by the reduction, on the side of the trial stress
  assign s_new = !plastic_r  ? s_r :
                 s_r[S_W-1]  ? (s_r + {1'b0, red_r}) : (s_r - {1'b0, red_r});

  assign os_full = {s_new[S_W-1], s_new} - {{(S_W+1-DATA_W){pre_r[DATA_W-1]}}, pre_r};
  assign os_hi   = os_full[S_W:DATA_W-1];
  assign stress_sat = ((&os_hi) || !(|os_hi)) ? os_full[DATA_W-1:0] :
                      (os_full[S_W] ? STRESS_MIN : STRESS_MAX);

  assign pl_ext = {{(PL_W-DATA_W){pl_r[DATA_W-1]}}, pl_r};
  assign pl_sum = s_r[S_W-1] ? (pl_ext - {2'b00, dg_r}) : (pl_ext + {2'b00, dg_r});
  assign pl_hi  = pl_sum[PL_W-1:DATA_W-1];
  assign pl_sat = ((&pl_hi) || !(|pl_hi)) ? pl_sum[DATA_W-1:0] :
                  (pl_sum[PL_W-1] ? STRESS_MIN : STRESS_MAX);
  assign new_pl = plastic_r ? pl_sat : pl_r;

  assign al_sum  = {{(DG_QB+1-MOD_W){1'b0}}, al_r} + {1'b0, dg_r};
  assign new_al  = !plastic_r ? al_r :
                   (|al_sum[DG_QB:MOD_W]) ? MOD_MAX : al_sum[MOD_W-1:0];
  assign tan_out = plastic_r ? tan_r : e_r;

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= PH_EL;
      out_valid_r <= 1'b0;
      e_r         <= MOD_W'(1);
      h_r         <= '0;
      ys_r        <= '0;
      pre_r       <= '0;
      pl_r        <= '0;
      al_r        <= '0;
      flag_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;

      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (fin_fire) begin
        flag_r <= plastic_r;
        if (commit_r) begin
          pl_r <= new_pl;
          al_r <= new_al;
        end
      end

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_YOUNGS: begin
            // a zero modulus behaves as one
            e_r <= (cfg_wdata[MOD_W-1:0] == '0) ? MOD_W'(1) : cfg_wdata[MOD_W-1:0];
          end
          CFG_HARDENING: h_r   <= cfg_wdata[MOD_W-1:0];
          CFG_YIELD:     ys_r  <= cfg_wdata[MOD_W-1:0];
          CFG_PRESTRESS: pre_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- datapath regs
  always_ff @(posedge clk) begin
    if (in_fire) begin
      strain_r   <= in_ch.axial_strain;
      commit_r   <= in_ch.mode;
      diff_neg_r <= diff[DATA_W];
      d_r        <= {1'b0, e_r} + {1'b0, h_r};
    end

    // shift-add multiplier, one modulus bit per cycle
    if (mul_start) begin
      a_r    <= mul_a_in;
      b_r    <= mul_b_in;
      acc_r  <= '0;
      mcnt_r <= '0;
    end else if (state_r == S_MUL) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r    <= a_r << 1;
      b_r    <= b_r >> 1;
      mcnt_r <= mcnt_r + 1'b1;
    end

    // restoring divider, one quotient bit per cycle
    if (div_start) begin
      rem_r  <= div_rem_in;
      num_r  <= div_num_in;
      quo_r  <= '0;
      dcnt_r <= div_cnt_in;
      ovf_r  <= div_ovf_in;
    end else if (state_r == S_DIV) begin
      rem_r  <= div_ge ? div_diff[DATA_W-1:0] : div_t[DATA_W-1:0];
      num_r  <= num_r << 1;
      quo_r  <= {quo_r[QN_W-2:0], div_ge};
      dcnt_r <= dcnt_r - 1'b1;
    end

    if (state_r == S_STEP) begin
      case (ph_r)
        PH_EL:      s_r       <= s_calc;
        PH_HARD:    f_r       <= f_calc;
        PH_CHECK:   plastic_r <= plastic_now;
        PH_RED_DIV: red_r     <= quo_r[MAG_W-1:0];
        PH_DG_DIV:  dg_r      <= dg_calc;
        PH_TAN_DIV: tan_r     <= quo_r[MOD_W-1:0];
        default: ;
      endcase
    end

    if (fin_fire) begin
      o_stress_r  <= stress_sat;
      o_tan_r     <= tan_out;
      o_plastic_r <= plastic_r;
      o_pl_r      <= new_pl;
      o_al_r      <= new_al;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.stress             = o_stress_r;
  assign out_ch.tangent_modulus    = o_tan_r;
  assign out_ch.plastic_step       = o_plastic_r;
  assign out_ch.plastic_strain_out = o_pl_r;
  assign out_ch.hardening_out      = o_al_r;

  // ---------------------------------------------------------------- assertions
  // an elastic result always carries the configured modulus
  a_elastic_tangent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.plastic_step) |-> (out_ch.tangent_modulus == e_r))
    else $error("elastic result with tangent other than E");

  // the stored plastic flag follows the result being offered
  a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.plastic_step == flag_r))
    else $error("plastic flag out of step with result");

  // divider partial remainder stays below E+H
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < d_r))
    else $error("divider remainder not below divisor");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives the truss return-mapping block with directed corner points and then
// random load paths under changing material settings; every result is checked
// field by field against a local integration of the same return map
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import trmp_pkg::*;

  localparam int FRAC           = 30;    // strain fraction bits of the instance
  localparam int RAND_POINTS    = 1950;  // random input transfers
  localparam int CALM_POINTS    = 200;   // closing stretch without idling
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer at all
  localparam int TAIL_CYCLES    = 320;   // beyond the slowest plastic point
  localparam int PHASE_SETTLE   = 4;

  // mode codes of an input transfer
  localparam logic TRIAL  = 1'b0;
  localparam logic COMMIT = 1'b1;

  localparam strain_t STRAIN_MAX = 32'sh7fff_ffff;
  localparam strain_t STRAIN_MIN = 32'sh8000_0000;
  localparam longint  S32_LO     = -64'sd2147483648;
  localparam longint  S32_HI     = 64'sd2147483647;

  // wide enough that no intermediate of the return map can overflow
  typedef logic signed [127:0] wide_t;

  localparam wide_t W_S32_MIN = -(wide_t'(1) <<< 31);
  localparam wide_t W_S32_MAX = (wide_t'(1) <<< 31) - 1;

  typedef struct {
    stress_t  stress;
    modulus_t tangent;
    logic     plastic;
    strain_t  eps_p;
    modulus_t alpha;
  } point_result_t;

  // --------------------------------------------------------------------------
  // material point tracker: mirrors the registers and the internal variables,
  // integrates each accepted strain and checks the results in order
  // --------------------------------------------------------------------------
  class return_map_tracker;
    wide_t youngs, hardening, yield_lim, prestress;
    wide_t eps_p, alpha;
    logic  last_plastic;
    point_result_t predicted_points[$];
    int    failures;

    function new();
      youngs       = 1;
      hardening    = 0;
      yield_lim    = 0;
      prestress    = 0;
      eps_p        = 0;
      alpha        = 0;
      last_plastic = 1'b0;
      failures     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        CFG_YOUNGS:    youngs    = wide_t'(data[MOD_W-1:0]);
        CFG_HARDENING: hardening = wide_t'(data[MOD_W-1:0]);
        CFG_YIELD:     yield_lim = wide_t'(data[MOD_W-1:0]);
        CFG_PRESTRESS: prestress = wide_t'(signed'(data));
        default: ;
      endcase
    endfunction

    function wide_t clamp(wide_t v, wide_t lo, wide_t hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // drop the strain fraction, half away from zero on a magnitude
    function wide_t scale_down(wide_t mag);
      return (mag + (wide_t'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function int pending();
      return predicted_points.size();
    endfunction

    function void note_strain(strain_t strain, logic commit);
      wide_t e, d, diff, mag, el, s, hard, f, q, r, dg, red;
      wide_t pl, al, s_new, tangent, out_s;
      logic yields;
      point_result_t res;
      e     = (youngs == 0) ? wide_t'(1) : youngs;   // zero modulus acts as one
      d     = e + hardening;
      diff  = wide_t'(strain) - eps_p;
      mag   = (diff < 0) ? -diff : diff;
      el    = scale_down(mag * e);
      s     = ((diff < 0) ? -el : el) + prestress;   // trial stress
      hard  = scale_down(hardening * alpha);
      f     = ((s < 0) ? -s : s) - (yield_lim + hard);
      yields = (f > 0);
      // total strain exactly balancing the prestress never yields
      if (e * wide_t'(strain) + (prestress <<< FRAC) == 0) yields = 1'b0;
      pl      = eps_p;
      al      = alpha;
      s_new   = s;
      tangent = e;
      if (yields) begin
        q = f / d;
        r = f % d;
        if (q >= (wide_t'(1) <<< (40 - FRAC))) begin
          dg = wide_t'(1) <<< 40;
        end else begin
          dg = (q <<< FRAC) + (r <<< FRAC) / d;
        end
        red = q * e + (r * e) / d;
        if (s > 0) begin
          s_new = s - red;
          pl    = pl + dg;
        end else begin
          s_new = s + red;
          pl    = pl - dg;
        end
        al      = clamp(al + dg, 0, W_S32_MAX);
        pl      = clamp(pl, W_S32_MIN, W_S32_MAX);
        tangent = (e * hardening) / d;
      end
      last_plastic = yields;
      if (commit) begin
        eps_p = pl;
        alpha = al;
      end
      out_s       = clamp(s_new - prestress, W_S32_MIN, W_S32_MAX);
      res.stress  = out_s[DATA_W-1:0];
      res.tangent = tangent[MOD_W-1:0];
      res.plastic = yields;
      res.eps_p   = pl[DATA_W-1:0];
      res.alpha   = al[MOD_W-1:0];
      predicted_points.push_back(res);
    endfunction

    function void check_field(string name, logic signed [63:0] want,
                              logic signed [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_response(stress_t st, modulus_t tg, logic pf, strain_t ep,
                                 modulus_t al);
      point_result_t want;
      if (predicted_points.size() == 0) begin
        $display("%0t: result with no point outstanding, expected none, actual stress %0d",
                 $time, st);
        failures++;
        return;
      end
      want = predicted_points.pop_front();
      check_field("stress", want.stress, st);
      check_field("tangent_modulus", want.tangent, tg);
      check_field("plastic_step", want.plastic, pf);
      check_field("plastic_strain_out", want.eps_p, ep);
      check_field("hardening_out", want.alpha, al);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and the block
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_wdata;

  trmp_in_if  in_ch ();
  trmp_out_if out_ch ();

  return_map_tracker tracker;
  bit calm = 1'b0;          // no idling on either side once set
  int points_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  truss_return_mapping_plasticity #(
    .STRAIN_FRAC_BITS(FRAC)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // --------------------------------------------------------------------------
  // result side: random stall bursts, checked at the edge
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(negedge clk) begin
    if (calm) begin
      out_ch.ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 2);   // random length for the rest of the burst
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      tracker.check_response(out_ch.stress, out_ch.tangent_modulus, out_ch.plastic_step,
                             out_ch.plastic_strain_out, out_ch.hardening_out);
    end
  end

  // watchdog: a hung handshake shows up as a long run with no transfer
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tracker.set_reg(idx, data);
  endtask

  task automatic set_material(logic [DATA_W-1:0] e, logic [DATA_W-1:0] h,
                              logic [DATA_W-1:0] y, logic [DATA_W-1:0] p);
    write_reg(CFG_YOUNGS, e);
    write_reg(CFG_HARDENING, h);
    write_reg(CFG_YIELD, y);
    write_reg(CFG_PRESTRESS, p);
  endtask

  // one strain transfer, with an optional input gap in front of it
  task automatic send_point(strain_t strain, logic commit);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.axial_strain <= strain;
    in_ch.mode         <= commit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_strain(strain, commit);
    points_sent++;
  endtask

  // stop sending and wait until every point has come back
  task automatic drain(int settle);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // strain at which E*strain + prestress*2^F is exactly zero, or zero if none
  function automatic strain_t balance_strain();
    longint e, num;
    e   = (tracker.youngs == 0) ? 64'sd1 : longint'(tracker.youngs);
    num = -(longint'(tracker.prestress) <<< FRAC);
    if (num % e == 0 && num / e >= S32_LO && num / e <= S32_HI) begin
      return strain_t'(num / e);
    end
    return '0;
  endfunction

  // material settings drawn around the extremes and around yield ~ E
  task automatic random_material();
    logic [DATA_W-1:0] e, e_eff, h, y, p;
    case ($urandom_range(0, 7))
      0:       e = 32'd1;
      1:       e = {1'b0, MOD_MAX};
      2:       e = 32'd0;
      3:       e = 32'd1 << FRAC;
      4:       e = $urandom_range(2, 4096);
      default: e = $urandom_range(32'h0001_0000, 32'h7fff_ffff);
    endcase
    e_eff = (e == 0) ? 32'd1 : e;
    case ($urandom_range(0, 5))
      0:       h = 32'd0;
      1:       h = {1'b0, MOD_MAX};
      2:       h = $urandom & 32'h7fff_ffff;
      default: h = e_eff >> $urandom_range(1, 8);
    endcase
    case ($urandom_range(0, 5))
      0:       y = 32'd0;
      1:       y = {1'b0, MOD_MAX};
      2:       y = $urandom & 32'h7fff_ffff;
      default: y = e_eff >> $urandom_range(0, 6);
    endcase
    case ($urandom_range(0, 6))
      0: p = 32'd0;
      1: p = STRESS_MIN;
      2: p = STRESS_MAX;
      3: p = $urandom;
      default: begin
        p = $urandom >> $urandom_range(4, 31);
        if ($urandom_range(0, 1)) p = -p;
      end
    endcase
    set_material(e, h, y, p);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int phase_goal, phase_start, rand_start, len, dir;
    int unsigned amp;
    longint cur;
    tracker            = new();
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_YOUNGS;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.axial_strain = '0;
    in_ch.mode         = TRIAL;
    out_ch.ready       = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings E=1, H=0, yield 0: any nonzero stress yields, and the
    // extreme strains drive alpha into saturation
    send_point(32'sd0, COMMIT);
    send_point(STRAIN_MAX, TRIAL);
    send_point(STRAIN_MIN, COMMIT);
    send_point(32'sd1, TRIAL);
    send_point(-32'sd1, COMMIT);
    drain(PHASE_SETTLE);

    // no hardening, stress equals strain: a large plastic strain makes the
    // balancing strain -prestress a yielding point that must stay elastic
    set_material(32'd1 << FRAC, 32'd0, 32'd1 << 26, 32'd1 << 20);
    send_point(32'sd0, TRIAL);
    send_point(STRAIN_MAX, COMMIT);
    send_point(-32'sd1048576, TRIAL);
    send_point(-32'sd1048576, COMMIT);
    send_point(STRAIN_MIN, COMMIT);
    send_point(32'sd1, TRIAL);
    drain(PHASE_SETTLE);

    // zero modulus with the largest prestress: dgamma hits its cap and the
    // plastic strain saturates
    set_material(32'd0, 32'd0, 32'd0, STRESS_MAX);
    send_point(32'sd0, COMMIT);
    send_point(STRAIN_MIN, TRIAL);
    drain(PHASE_SETTLE);

    // every register at its top, prestress at the bottom: stress saturation
    set_material({1'b0, MOD_MAX}, {1'b0, MOD_MAX}, {1'b0, MOD_MAX}, STRESS_MIN);
    send_point(STRAIN_MAX, COMMIT);
    send_point(STRAIN_MIN, COMMIT);
    send_point(32'sd0, TRIAL);
    send_point(STRAIN_MAX, TRIAL);

    // random phases: mostly load paths with trial/commit pairs, some noise
    rand_start = points_sent;
    while (points_sent - rand_start < RAND_POINTS) begin
      drain(PHASE_SETTLE);
      random_material();
      phase_goal  = $urandom_range(100, 220);
      phase_start = points_sent;
      cur         = 0;
      while (points_sent - phase_start < phase_goal &&
             points_sent - rand_start < RAND_POINTS) begin
        calm = (points_sent - rand_start >= RAND_POINTS - CALM_POINTS);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            // monotonic loading with occasional reversals
            len = $urandom_range(4, 24);
            amp = 32'd1 << $urandom_range(14, 30);
            dir = $urandom_range(0, 1) ? 1 : -1;
            repeat (len) begin
              if ($urandom_range(0, 5) == 0) dir = -dir;
              cur = cur + dir * longint'($urandom_range(0, amp));
              if (cur > S32_HI) cur = S32_HI;
              if (cur < S32_LO) cur = S32_LO;
              case ($urandom_range(0, 3))
                0: send_point(strain_t'(cur), COMMIT);
                1: begin
                  send_point(strain_t'(cur), TRIAL);
                  send_point(strain_t'(cur), COMMIT);
                end
                2: begin
                  send_point(strain_t'(cur) + strain_t'($urandom_range(0, 255)), TRIAL);
                  send_point(strain_t'(cur), COMMIT);
                end
                default: send_point(strain_t'(cur), TRIAL);
              endcase
            end
          end
          6, 7: send_point($urandom, $urandom_range(0, 1));
          8: begin
            case ($urandom_range(0, 6))
              0: send_point(STRAIN_MAX, $urandom_range(0, 1));
              1: send_point(STRAIN_MIN, $urandom_range(0, 1));
              2: send_point(32'sd0, $urandom_range(0, 1));
              3: send_point(32'sd1, $urandom_range(0, 1));
              4: send_point(-32'sd1, $urandom_range(0, 1));
              5: send_point(balance_strain(), $urandom_range(0, 1));
              default: send_point(tracker.eps_p[DATA_W-1:0], $urandom_range(0, 1));
            endcase
          end
          default: begin
            // trials that are never committed
            repeat ($urandom_range(2, 6)) begin
              send_point(strain_t'(cur) ^ strain_t'($urandom >> $urandom_range(0, 31)),
                         TRIAL);
            end
          end
        endcase
      end
    end

    drain(TAIL_CYCLES);
    if (tracker.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
